// ===== hw/rtl/twdbg_pkg.sv =====
// ----------------------------------------------------------------------------
// twdbg_pkg
// shared types and constants of the two-wire debug command master
// ----------------------------------------------------------------------------
package twdbg_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_BYTE_A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_BYTE_B  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INSTR_CODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_CODE  = 3'd5;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd1;
    localparam logic [7:0]  RETRY_LIMIT_RST = 8'd1;
    localparam logic [4:0]  TWO_BYTE_A_RST  = 5'd5;
    localparam logic [4:0]  TWO_BYTE_B_RST  = 5'd13;
    localparam logic [4:0]  INSTR_CODE_RST  = 5'd10;
    localparam logic [4:0]  BURST_CODE_RST  = 5'd16;

    localparam logic [1:0] OP_IDLE  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;
    localparam logic [1:0] OP_RESET = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [4:0]  command_code;
        logic [10:0] data_length;
        logic [7:0]  data_byte;
        logic        dd_sample;
    } in_t;

    typedef struct packed {
        logic       clock_level;
        logic       data_level;
        logic       data_drive;
        logic       reset_level;
        logic       need_byte;
        logic       reply_valid;
        logic [7:0] reply_byte;
        logic       done_res;
        logic       failed;
        logic       busy_res;
    } out_t;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [7:0]  retry_limit;
        logic [4:0]  two_byte_code_a;
        logic [4:0]  two_byte_code_b;
        logic [4:0]  instr_code;
        logic [4:0]  burst_code;
    } cfg_t;

endpackage

// ===== hw/rtl/twdbg_core.sv =====
// ----------------------------------------------------------------------------
// twdbg_core
// pin-level sequencer: one tick per request, result formed from next state
// ----------------------------------------------------------------------------
module twdbg_core
    import twdbg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  in_t  item,
    input  cfg_t cfg,
    output out_t res
);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_WR_HIGH  = 4'd1,
        PH_WR_LOW   = 4'd2,
        PH_NEED     = 4'd3,
        PH_POLL     = 4'd4,
        PH_RD_HIGH  = 4'd5,
        PH_RD_LOW   = 4'd6,
        PH_DUM_HIGH = 4'd7,
        PH_DUM_LOW  = 4'd8,
        PH_GAP      = 4'd9,
        PH_R_PRE    = 4'd10,
        PH_R_LOW    = 4'd11,
        PH_R_TH     = 4'd12,
        PH_R_TL     = 4'd13,
        PH_R_POST   = 4'd14
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] delay_reg, delay_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [10:0] bytes_reg, bytes_next;
    logic [1:0]  reply_reg, reply_next;
    logic [7:0]  retries_reg, retries_next;
    logic        burst_reg, burst_next;
    logic        clock_reg, clock_next;
    logic        reset_reg, reset_next;

    logic [15:0] hp_eff;
    logic [7:0]  cb;
    logic [3:0]  bit_dec;
    logic [1:0]  reply_dec;
    logic        rvalid;
    logic [7:0]  rbyte;
    logic        done;
    logic        fail;
    logic        drive;

    always_comb
    begin
        phase_next   = phase_reg;
        delay_next   = delay_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        bytes_next   = bytes_reg;
        reply_next   = reply_reg;
        retries_next = retries_reg;
        burst_next   = burst_reg;
        clock_next   = clock_reg;
        reset_next   = reset_reg;
        rvalid       = 1'b0;
        rbyte        = 8'd0;
        done         = 1'b0;
        fail         = 1'b0;
        hp_eff       = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
        cb           = {item.command_code, 3'b000};
        bit_dec      = bit_reg - 4'd1;
        reply_dec    = reply_reg - 2'd1;

        if (phase_reg == PH_IDLE)
        begin
            if (item.opcode == OP_START)
            begin
                burst_next = 1'b0;
                reply_next = 2'd1;
                if (item.command_code == cfg.instr_code)
                begin
                    cb[2:0] = {1'b0, item.data_length[1:0]};
                end
                else if (item.command_code == cfg.burst_code)
                begin
                    cb[2:0]    = item.data_length[10:8];
                    burst_next = 1'b1;
                end
                else if (item.command_code == cfg.two_byte_code_a
                         || item.command_code == cfg.two_byte_code_b)
                begin
                    reply_next = 2'd2;
                end
                bytes_next   = item.data_length;
                retries_next = cfg.retry_limit;
                shift_next   = cb;
                bit_next     = 4'd8;
                clock_next   = 1'b1;
                phase_next   = PH_WR_HIGH;
                delay_next   = hp_eff;
            end
            else if (item.opcode == OP_RESET)
            begin
                reset_next = 1'b1;
                clock_next = 1'b0;
                phase_next = PH_R_PRE;
                delay_next = hp_eff;
            end
        end
        else if (phase_reg == PH_NEED)
        begin
            if (item.opcode == OP_DATA)
            begin
                bytes_next = bytes_reg - 11'd1;
                shift_next = item.data_byte;
                bit_next   = 4'd8;
                clock_next = 1'b1;
                phase_next = PH_WR_HIGH;
                delay_next = hp_eff;
            end
        end
        else if (delay_reg > 16'd1)
        begin
            delay_next = delay_reg - 16'd1;
        end
        else
        begin
            case (phase_reg)
                PH_WR_HIGH:
                begin
                    clock_next = 1'b0;
                    phase_next = PH_WR_LOW;
                    delay_next = hp_eff;
                end
                PH_WR_LOW:
                begin
                    bit_next   = bit_dec;
                    shift_next = {shift_reg[6:0], 1'b0};
                    if (bit_dec != 4'd0)
                    begin
                        clock_next = 1'b1;
                        phase_next = PH_WR_HIGH;
                        delay_next = hp_eff;
                    end
                    else if (burst_reg)
                    begin
                        // second length byte of a burst write
                        burst_next = 1'b0;
                        shift_next = bytes_reg[7:0];
                        bit_next   = 4'd8;
                        clock_next = 1'b1;
                        phase_next = PH_WR_HIGH;
                        delay_next = hp_eff;
                    end
                    else if (bytes_reg != 11'd0)
                    begin
                        phase_next = PH_NEED;
                    end
                    else
                    begin
                        phase_next = PH_POLL;
                        delay_next = hp_eff;
                    end
                end
                PH_POLL:
                begin
                    if (!item.dd_sample)
                    begin
                        shift_next = 8'd0;
                        bit_next   = 4'd8;
                        clock_next = 1'b1;
                        phase_next = PH_RD_HIGH;
                        delay_next = hp_eff;
                    end
                    else if (retries_reg == 8'd0)
                    begin
                        done       = 1'b1;
                        fail       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        retries_next = retries_reg - 8'd1;
                        shift_next   = 8'd0;
                        bit_next     = 4'd8;
                        clock_next   = 1'b1;
                        phase_next   = PH_DUM_HIGH;
                        delay_next   = hp_eff;
                    end
                end
                PH_RD_HIGH:
                begin
                    clock_next = 1'b0;
                    shift_next = {shift_reg[6:0], item.dd_sample};
                    phase_next = PH_RD_LOW;
                    delay_next = hp_eff;
                end
                PH_RD_LOW:
                begin
                    bit_next = bit_dec;
                    if (bit_dec != 4'd0)
                    begin
                        clock_next = 1'b1;
                        phase_next = PH_RD_HIGH;
                        delay_next = hp_eff;
                    end
                    else
                    begin
                        rvalid     = 1'b1;
                        rbyte      = shift_reg;
                        reply_next = reply_dec;
                        if (reply_dec != 2'd0)
                        begin
                            shift_next = 8'd0;
                            bit_next   = 4'd8;
                            clock_next = 1'b1;
                            phase_next = PH_RD_HIGH;
                            delay_next = hp_eff;
                        end
                        else
                        begin
                            done       = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_DUM_HIGH:
                begin
                    clock_next = 1'b0;
                    phase_next = PH_DUM_LOW;
                    delay_next = hp_eff;
                end
                PH_DUM_LOW:
                begin
                    bit_next   = bit_dec;
                    delay_next = hp_eff;
                    if (bit_dec != 4'd0)
                    begin
                        clock_next = 1'b1;
                        phase_next = PH_DUM_HIGH;
                    end
                    else
                    begin
                        phase_next = PH_GAP;
                    end
                end
                PH_GAP:
                begin
                    phase_next = PH_POLL;
                    delay_next = hp_eff;
                end
                PH_R_PRE:
                begin
                    reset_next = 1'b0;
                    phase_next = PH_R_LOW;
                    delay_next = hp_eff;
                end
                PH_R_LOW:
                begin
                    clock_next = 1'b1;
                    bit_next   = 4'd2;
                    phase_next = PH_R_TH;
                    delay_next = hp_eff;
                end
                PH_R_TH:
                begin
                    clock_next = 1'b0;
                    phase_next = PH_R_TL;
                    delay_next = hp_eff;
                end
                PH_R_TL:
                begin
                    bit_next   = bit_dec;
                    delay_next = hp_eff;
                    if (bit_dec != 4'd0)
                    begin
                        clock_next = 1'b1;
                        phase_next = PH_R_TH;
                    end
                    else
                    begin
                        reset_next = 1'b1;
                        phase_next = PH_R_POST;
                    end
                end
                PH_R_POST:
                begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        drive = phase_next inside {PH_WR_HIGH, PH_WR_LOW, PH_NEED};

        res.clock_level = clock_next;
        res.data_level  = drive & shift_next[7];
        res.data_drive  = drive;
        res.reset_level = reset_next;
        res.need_byte   = (phase_next == PH_NEED);
        res.reply_valid = rvalid;
        res.reply_byte  = rbyte;
        res.done_res    = done;
        res.failed      = fail;
        res.busy_res    = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            delay_reg   <= 16'd0;
            bit_reg     <= 4'd0;
            shift_reg   <= 8'd0;
            bytes_reg   <= 11'd0;
            reply_reg   <= 2'd0;
            retries_reg <= 8'd0;
            burst_reg   <= 1'b0;
            clock_reg   <= 1'b0;
            reset_reg   <= 1'b1;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            delay_reg   <= delay_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            bytes_reg   <= bytes_next;
            reply_reg   <= reply_next;
            retries_reg <= retries_next;
            burst_reg   <= burst_next;
            clock_reg   <= clock_next;
            reset_reg   <= reset_next;
        end
    end

endmodule

// ===== hw/rtl/two_wire_debug_command_master.sv =====
// ----------------------------------------------------------------------------
// two_wire_debug_command_master
// host side of a two-wire debug port, advanced by one tick per input request
// ----------------------------------------------------------------------------
//  channel   signals                         width      role
//  in        in_valid / in_ready / in_data   in_t       one timing tick
//  out       out_valid / out_ready / out_data out_t     pin levels and status
//  cfg       cfg_we / cfg_index / cfg_data   3 / 16     register write
//
//  one request per clock while in_ready is high; each tick is handled in a
//  single pass through the sequencer and is registered when it is accepted
//  in_ready stays high while the output register is empty or being drained
//  a result waiting with out_ready low is held and drops in_ready at once
//  reset clears the sequencer to idle with the target reset line high
// ----------------------------------------------------------------------------
module two_wire_debug_command_master
    import twdbg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    logic out_valid_reg;
    out_t out_data_reg;
    out_t res;
    logic step;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks <= HALF_PERIOD_RST;
            cfg_reg.retry_limit       <= RETRY_LIMIT_RST;
            cfg_reg.two_byte_code_a   <= TWO_BYTE_A_RST;
            cfg_reg.two_byte_code_b   <= TWO_BYTE_B_RST;
            cfg_reg.instr_code        <= INSTR_CODE_RST;
            cfg_reg.burst_code        <= BURST_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HALF_PERIOD: cfg_reg.half_period_ticks <= cfg_data;
                CFG_RETRY_LIMIT: cfg_reg.retry_limit       <= cfg_data[7:0];
                CFG_TWO_BYTE_A:  cfg_reg.two_byte_code_a   <= cfg_data[4:0];
                CFG_TWO_BYTE_B:  cfg_reg.two_byte_code_b   <= cfg_data[4:0];
                CFG_INSTR_CODE:  cfg_reg.instr_code        <= cfg_data[4:0];
                CFG_BURST_CODE:  cfg_reg.burst_code        <= cfg_data[4:0];
                default:         ;
            endcase
        end
    end

    twdbg_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_data),
        .cfg   (cfg_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/twdbg_checker.sv =====
// ----------------------------------------------------------------------------
// twdbg_checker
// port-level checks of the two-wire debug command master
// ----------------------------------------------------------------------------
module twdbg_checker
    import twdbg_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // an empty output stage never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // every accepted request yields a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted request gave no result");

    // failure only reported together with done
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.failed |-> out_data.done_res)
        else $error("failed without done");

    // released data line shows low, idle shows no drive
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.busy_res |-> !out_data.data_drive && !out_data.data_level)
        else $error("data line driven while idle");

endmodule

bind two_wire_debug_command_master twdbg_checker u_twdbg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/two_wire_debug_command_master_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_wire_debug_command_master_tb
// feeds timing ticks into the debug command master and checks the pin levels
// and status of every tick against a tick-exact model of the sequencer kept
// in a small scoreboard; directed commands first, then random command mixes
// under several register settings, with random idling on both channels
// ----------------------------------------------------------------------------
module two_wire_debug_command_master_tb;
    import twdbg_pkg::*;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_WR_HIGH, SEQ_WR_LOW, SEQ_NEED, SEQ_POLL, SEQ_RD_HIGH, SEQ_RD_LOW,
        SEQ_DUM_HIGH, SEQ_DUM_LOW, SEQ_GAP, SEQ_R_PRE, SEQ_R_LOW, SEQ_R_TH, SEQ_R_TL,
        SEQ_R_POST
    } seq_phase_t;

    class pin_level_checker;
        cfg_t        regs;
        seq_phase_t  ph;
        logic [15:0] ticks;
        logic [3:0]  bits_left;
        logic [7:0]  shifter;
        logic [10:0] bytes_owed;
        logic [1:0]  replies_owed;
        logic [7:0]  polls_left;
        logic        length_pending;
        logic        sck;
        logic        trst_n;
        out_t        expected_pins[$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned commands;
        int unsigned resets;
        int unsigned reply_bytes;
        int unsigned timeouts;

        function new();
            regs = {HALF_PERIOD_RST, RETRY_LIMIT_RST, TWO_BYTE_A_RST, TWO_BYTE_B_RST,
                    INSTR_CODE_RST, BURST_CODE_RST};
            ph = SEQ_IDLE;
            ticks = '0;
            bits_left = '0;
            shifter = '0;
            bytes_owed = '0;
            replies_owed = '0;
            polls_left = '0;
            length_pending = 1'b0;
            sck = 1'b0;
            trst_n = 1'b1;
            mismatches = 0;
            results_seen = 0;
            commands = 0;
            resets = 0;
            reply_bytes = 0;
            timeouts = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_HALF_PERIOD: regs.half_period_ticks = val;
                CFG_RETRY_LIMIT: regs.retry_limit = val[7:0];
                CFG_TWO_BYTE_A:  regs.two_byte_code_a = val[4:0];
                CFG_TWO_BYTE_B:  regs.two_byte_code_b = val[4:0];
                CFG_INSTR_CODE:  regs.instr_code = val[4:0];
                CFG_BURST_CODE:  regs.burst_code = val[4:0];
                default: ;
            endcase
        endfunction

        function void enter_phase(seq_phase_t p);
            ph = p;
            ticks = (regs.half_period_ticks != 0) ? regs.half_period_ticks : 16'd1;
        endfunction

        function void load_byte(seq_phase_t p, logic [7:0] b);
            shifter = b;
            bits_left = 4'd8;
            sck = 1'b1;
            enter_phase(p);
        endfunction

        function out_t advance_tick(in_t x);
            out_t       r;
            logic       drive;
            logic [7:0] cmd;
            r = '0;
            if (ph == SEQ_IDLE)
            begin
                if (x.opcode == OP_START)
                begin
                    cmd = {x.command_code, 3'b000};
                    length_pending = 1'b0;
                    replies_owed = 2'd1;
                    if (x.command_code == regs.instr_code)
                        cmd[1:0] = x.data_length[1:0];
                    else if (x.command_code == regs.burst_code)
                    begin
                        cmd[2:0] = x.data_length[10:8];
                        length_pending = 1'b1;
                    end
                    else if (x.command_code == regs.two_byte_code_a ||
                             x.command_code == regs.two_byte_code_b)
                        replies_owed = 2'd2;
                    bytes_owed = x.data_length;
                    polls_left = regs.retry_limit;
                    load_byte(SEQ_WR_HIGH, cmd);
                    commands++;
                end
                else if (x.opcode == OP_RESET)
                begin
                    trst_n = 1'b1;
                    sck = 1'b0;
                    enter_phase(SEQ_R_PRE);
                    resets++;
                end
            end
            else if (ph == SEQ_NEED)
            begin
                if (x.opcode == OP_DATA)
                begin
                    bytes_owed--;
                    load_byte(SEQ_WR_HIGH, x.data_byte);
                end
            end
            else if (ticks > 16'd1)
            begin
                ticks--;
            end
            else
            begin
                case (ph)
                    SEQ_WR_HIGH:
                    begin
                        sck = 1'b0;
                        enter_phase(SEQ_WR_LOW);
                    end
                    SEQ_WR_LOW:
                    begin
                        bits_left--;
                        shifter = shifter << 1;
                        if (bits_left != 0)
                        begin
                            sck = 1'b1;
                            enter_phase(SEQ_WR_HIGH);
                        end
                        else if (length_pending)
                        begin
                            length_pending = 1'b0;
                            load_byte(SEQ_WR_HIGH, bytes_owed[7:0]);
                        end
                        else if (bytes_owed != 0)
                            ph = SEQ_NEED;
                        else
                            enter_phase(SEQ_POLL);
                    end
                    SEQ_POLL:
                    begin
                        if (!x.dd_sample)
                            load_byte(SEQ_RD_HIGH, 8'h00);
                        else if (polls_left == 0)
                        begin
                            r.done_res = 1'b1;
                            r.failed = 1'b1;
                            ph = SEQ_IDLE;
                            timeouts++;
                        end
                        else
                        begin
                            polls_left--;
                            load_byte(SEQ_DUM_HIGH, 8'h00);
                        end
                    end
                    SEQ_RD_HIGH:
                    begin
                        sck = 1'b0;
                        shifter = {shifter[6:0], x.dd_sample};
                        enter_phase(SEQ_RD_LOW);
                    end
                    SEQ_RD_LOW:
                    begin
                        bits_left--;
                        if (bits_left != 0)
                        begin
                            sck = 1'b1;
                            enter_phase(SEQ_RD_HIGH);
                        end
                        else
                        begin
                            r.reply_valid = 1'b1;
                            r.reply_byte = shifter;
                            reply_bytes++;
                            replies_owed--;
                            if (replies_owed != 0)
                                load_byte(SEQ_RD_HIGH, 8'h00);
                            else
                            begin
                                r.done_res = 1'b1;
                                ph = SEQ_IDLE;
                            end
                        end
                    end
                    SEQ_DUM_HIGH:
                    begin
                        sck = 1'b0;
                        enter_phase(SEQ_DUM_LOW);
                    end
                    SEQ_DUM_LOW:
                    begin
                        bits_left--;
                        if (bits_left != 0)
                        begin
                            sck = 1'b1;
                            enter_phase(SEQ_DUM_HIGH);
                        end
                        else
                            enter_phase(SEQ_GAP);
                    end
                    SEQ_GAP: enter_phase(SEQ_POLL);
                    SEQ_R_PRE:
                    begin
                        trst_n = 1'b0;
                        enter_phase(SEQ_R_LOW);
                    end
                    SEQ_R_LOW:
                    begin
                        sck = 1'b1;
                        bits_left = 4'd2;
                        enter_phase(SEQ_R_TH);
                    end
                    SEQ_R_TH:
                    begin
                        sck = 1'b0;
                        enter_phase(SEQ_R_TL);
                    end
                    SEQ_R_TL:
                    begin
                        bits_left--;
                        if (bits_left != 0)
                        begin
                            sck = 1'b1;
                            enter_phase(SEQ_R_TH);
                        end
                        else
                        begin
                            trst_n = 1'b1;
                            enter_phase(SEQ_R_POST);
                        end
                    end
                    SEQ_R_POST:
                    begin
                        r.done_res = 1'b1;
                        ph = SEQ_IDLE;
                    end
                    default: ph = SEQ_IDLE;
                endcase
            end
            drive = (ph == SEQ_WR_HIGH || ph == SEQ_WR_LOW || ph == SEQ_NEED);
            r.clock_level = sck;
            r.data_level = drive & shifter[7];
            r.data_drive = drive;
            r.reset_level = trst_n;
            r.need_byte = (ph == SEQ_NEED);
            r.busy_res = (ph != SEQ_IDLE);
            return r;
        endfunction

        function void note_request(in_t x);
            expected_pins.push_back(advance_tick(x));
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("result %0d: %s got %0h expected %0h", results_seen, what, got, want);
            mismatches++;
        endtask

        task compare(string what, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch(what, got, want);
        endtask

        task check_pins(out_t got);
            out_t want;
            results_seen++;
            if (expected_pins.size() == 0)
            begin
                report_mismatch("unexpected result", 32'(got), 0);
                return;
            end
            want = expected_pins.pop_front();
            compare("clock_level", 32'(got.clock_level), 32'(want.clock_level));
            compare("data_level", 32'(got.data_level), 32'(want.data_level));
            compare("data_drive", 32'(got.data_drive), 32'(want.data_drive));
            compare("reset_level", 32'(got.reset_level), 32'(want.reset_level));
            compare("need_byte", 32'(got.need_byte), 32'(want.need_byte));
            compare("reply_valid", 32'(got.reply_valid), 32'(want.reply_valid));
            compare("reply_byte", 32'(got.reply_byte), 32'(want.reply_byte));
            compare("done_res", 32'(got.done_res), 32'(want.done_res));
            compare("failed", 32'(got.failed), 32'(want.failed));
            compare("busy_res", 32'(got.busy_res), 32'(want.busy_res));
        endtask

        task close_out();
            if (expected_pins.size() != 0)
                report_mismatch("results never seen", expected_pins.size(), 0);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_t                   in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_t                  out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  calm = 1'b0;
    int unsigned           ready_pct = 50;
    int unsigned           supply_pct = 80;
    logic [7:0]            byte_plan[$];
    pin_level_checker      pin_check;

    two_wire_debug_command_master i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            out_ready <= calm || ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            pin_check.check_pins(out_data);
    end

    function automatic logic take_gap();
        return !calm && ($urandom_range(0, 99) < 16);
    endfunction

    function automatic int unsigned ready_odds();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        else if (r < 3)
            return 25;
        else if (r < 6)
            return 60;
        return 100;
    endfunction

    function automatic in_t junk_tick(logic [1:0] op);
        in_t t;
        t.opcode = op;
        t.command_code = 5'($urandom_range(0, 31));
        t.data_length = 11'($urandom_range(0, 2047));
        t.data_byte = 8'($urandom_range(0, 255));
        t.dd_sample = 1'($urandom_range(0, 1));
        return t;
    endfunction

    // next tick while a sequence runs: bytes when asked, some stray starts, bytes and resets
    function automatic in_t busy_tick();
        in_t        t;
        logic [1:0] op;
        op = OP_IDLE;
        if (pin_check.ph == SEQ_NEED && $urandom_range(0, 99) < supply_pct)
            op = OP_DATA;
        else if ($urandom_range(0, 99) < 12)
        begin
            case ($urandom_range(0, 2))
                0: op = OP_START;
                1: op = OP_DATA;
                default: op = OP_RESET;
            endcase
        end
        t = junk_tick(op);
        if (pin_check.ph == SEQ_NEED && op == OP_DATA && byte_plan.size() != 0)
            t.data_byte = byte_plan.pop_front();
        if (pin_check.ph == SEQ_POLL)
            t.dd_sample = ($urandom_range(0, 99) < ready_pct) ? 1'b0 : 1'b1;
        return t;
    endfunction

    function automatic in_t command_tick();
        in_t         t;
        int unsigned r;
        t = junk_tick(OP_START);
        r = $urandom_range(0, 9);
        if (r < 3)
            t.command_code = pin_check.regs.instr_code;
        else if (r < 5)
            t.command_code = pin_check.regs.burst_code;
        else if (r == 5)
            t.command_code = pin_check.regs.two_byte_code_a;
        else if (r == 6)
            t.command_code = pin_check.regs.two_byte_code_b;
        r = $urandom_range(0, 99);
        if (r < 70)
            t.data_length = 11'($urandom_range(0, 3));
        else if (r < 95)
            t.data_length = 11'($urandom_range(3, 6));
        else
            t.data_length = 11'($urandom_range(7, 12));
        return t;
    endfunction

    task automatic send_tick(input in_t item);
        while (take_gap())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
        pin_check.note_request(item);
    endtask

    task automatic finish_sequence();
        while (pin_check.ph != SEQ_IDLE)
            send_tick(busy_tick());
    endtask

    task automatic start_command(input logic [4:0] code, input logic [10:0] len);
        in_t t;
        t = junk_tick(OP_START);
        t.command_code = code;
        t.data_length = len;
        send_tick(t);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pin_check.expected_pins.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        pin_check.set_reg(idx, val);
    endtask

    task automatic apply_settings(input logic [15:0] half, input logic [7:0] retry,
                                  input logic [4:0] code_a, input logic [4:0] code_b,
                                  input logic [4:0] code_i, input logic [4:0] code_w);
        settle();
        put_reg(CFG_HALF_PERIOD, half);
        put_reg(CFG_RETRY_LIMIT, 16'(retry));
        put_reg(CFG_TWO_BYTE_A, 16'(code_a));
        put_reg(CFG_TWO_BYTE_B, 16'(code_b));
        put_reg(CFG_INSTR_CODE, 16'(code_i));
        put_reg(CFG_BURST_CODE, 16'(code_w));
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int unsigned budget);
        int unsigned n;
        int unsigned pick;
        in_t         t;
        supply_pct = $urandom_range(60, 95);
        for (n = 0; n < budget; n++)
        begin
            if (pin_check.ph != SEQ_IDLE)
                t = busy_tick();
            else
            begin
                pick = $urandom_range(0, 99);
                ready_pct = ready_odds();
                if (pick < 78)
                    t = command_tick();
                else if (pick < 88)
                    t = junk_tick(OP_RESET);
                else
                    t = junk_tick(($urandom_range(0, 1) != 0) ? OP_DATA : OP_IDLE);
            end
            send_tick(t);
        end
        finish_sequence();
    endtask

    initial
    begin
        logic [4:0] shared;
        pin_check = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick(junk_tick(OP_DATA));
        send_tick(junk_tick(OP_RESET));
        finish_sequence();

        ready_pct = 100;
        byte_plan.push_back(8'hff);
        byte_plan.push_back(8'h00);
        byte_plan.push_back(8'h80);
        start_command(INSTR_CODE_RST, 11'd3);
        send_tick(junk_tick(OP_START));
        send_tick(junk_tick(OP_RESET));
        finish_sequence();
        start_command(INSTR_CODE_RST, 11'd0);
        finish_sequence();
        start_command(BURST_CODE_RST, 11'd1);
        finish_sequence();
        start_command(TWO_BYTE_A_RST, 11'd1);
        finish_sequence();
        start_command(TWO_BYTE_B_RST, 11'd0);
        finish_sequence();
        start_command(5'd0, 11'd2);
        finish_sequence();
        ready_pct = 0;
        start_command(5'd31, 11'd0);
        finish_sequence();
        ready_pct = 50;
        supply_pct = 15;
        start_command(5'd31, 11'd2);
        finish_sequence();
        ready_pct = 40;
        start_command(5'd31, 11'd0);
        finish_sequence();
        supply_pct = 90;
        ready_pct = 100;
        start_command(BURST_CODE_RST, 11'd2);
        finish_sequence();

        apply_settings(16'd0, 8'd0, 5'd31, 5'd31, 5'd31, 5'd31);
        random_phase(40);
        apply_settings(16'd2, 8'd4, 5'd0, 5'd31, 5'd7, 5'd24);
        random_phase(40);
        calm = 1'b1;
        apply_settings(16'd2, 8'd2, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                       5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
        random_phase(40);
        calm = 1'b0;
        shared = 5'($urandom_range(0, 31));
        apply_settings(16'd1, 8'($urandom_range(0, 4)), shared, shared,
                       5'($urandom_range(0, 31)), shared);
        random_phase(40);
        calm = 1'b1;
        apply_settings(16'd12, RETRY_LIMIT_RST, TWO_BYTE_A_RST, TWO_BYTE_B_RST,
                       INSTR_CODE_RST, BURST_CODE_RST);
        send_tick(junk_tick(OP_RESET));
        finish_sequence();
        calm = 1'b0;
        apply_settings(16'($urandom_range(1, 2)), 8'($urandom_range(0, 4)), TWO_BYTE_A_RST,
                       TWO_BYTE_B_RST, INSTR_CODE_RST, BURST_CODE_RST);
        random_phase(40);

        settle();
        pin_check.close_out();
        $display("%0d ticks checked: %0d commands, %0d debug resets, %0d reply bytes",
                 pin_check.results_seen, pin_check.commands, pin_check.resets,
                 pin_check.reply_bytes);
        $display("%0d ready timeouts, %0d mismatching fields",
                 pin_check.timeouts, pin_check.mismatches);
        if (pin_check.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("simulation failed");
        $finish;
    end

endmodule
